/* hw/rtl/elgh_pkg.sv */
package elgh_pkg;

	// defaults for the top level parameters
	localparam int COORD_BITS_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;

	// internal widths, sized for the full parameter range
	localparam int DIFF_W     = 33;  // |dx|, |dy|
	localparam int SQ_W       = 66;  // dx^2 + dy^2
	localparam int ROOT_W     = 34;
	localparam int SREM_W     = 35;  // sqrt remainder, below 2*root+1
	localparam int LEN_W      = 34;
	localparam int UNIT_SHIFT = 30;
	localparam int UX_W       = 31;  // unit magnitude, at most 2^30
	localparam int PROD_W     = 62;
	localparam int NUM_W      = 64;
	localparam int HQ_W       = 32;  // Hessian quotient bits before saturation

	// one input beat
	typedef struct packed {
		logic signed [31:0] first_x;
		logic signed [31:0] first_y;
		logic signed [31:0] second_x;
		logic signed [31:0] second_y;
	} pair_t;

	// one result beat
	typedef struct packed {
		logic [32:0]        edge_length;
		logic signed [31:0] unit_x;
		logic signed [31:0] unit_y;
		logic signed [31:0] hess_xx;
		logic signed [31:0] hess_xy;
		logic signed [31:0] hess_yy;
		logic               degenerate;
	} result_t;

	// data riding along the square root pipe
	typedef struct packed {
		logic              sx;
		logic              sy;
		logic [DIFF_W-1:0] ax;
		logic [DIFF_W-1:0] ay;
		logic              deg;
	} sq_side_t;

	// data riding along the unit vector divider
	typedef struct packed {
		logic [LEN_W-1:0] len;
		logic             sx;
		logic             sy;
		logic             deg;
	} ud_side_t;

	// data riding along the Hessian divider
	typedef struct packed {
		logic [2:0]       ovf;
		logic             hz;
		logic [LEN_W-1:0] len;
		logic [UX_W-1:0]  ux;
		logic [UX_W-1:0]  uy;
		logic             sx;
		logic             sy;
		logic             deg;
	} hd_side_t;

endpackage

/* hw/rtl/elgh_if.sv */
interface elgh_pair_if;
	import elgh_pkg::*;

	logic  valid;
	logic  ready;
	pair_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface elgh_res_if;
	import elgh_pkg::*;

	logic    valid;
	logic    ready;
	result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/edge_length_grad_hessian_unit.sv */
// Edge length, gradient and Hessian block of a 2D edge.
// Throughput: one beat per cycle unless stalled; the bit-per-stage square
// root (34 stages) and dividers (31 and 32 stages) are fully pipelined.
// A held result stalls the whole pipe; no beat is lost or repeated.
// Reset (arst_n low) clears all valid bits; payload registers are not reset.
module edge_length_grad_hessian_unit #(
	parameter int COORD_BITS = elgh_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = elgh_pkg::FRAC_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	elgh_pair_if.sink pair,
	elgh_res_if.source res
);
	import elgh_pkg::*;

	localparam int CW  = (COORD_BITS < 32) ? COORD_BITS : 32;
	localparam int HSH = 2 * UNIT_SHIFT - 2 * FRAC_BITS;
	localparam logic [NUM_W-1:0] ONE_SQ = NUM_W'(1) << (2 * UNIT_SHIFT);
	localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] NEG_MAX = 32'h8000_0000;

	logic en;

	// coordinate signed in COORD_BITS bits; taken unsigned if COORD_BITS > 32
	function automatic logic signed [DIFF_W-1:0] coord_of(input logic [31:0] raw);
		logic signed [31:0] t;
		t = $signed(raw << (32 - CW)) >>> (32 - CW);
		if (COORD_BITS > 32) begin
			return {1'b0, raw};
		end
		return {t[31], t};
	endfunction

	// signed saturation of a magnitude to 32 bits
	function automatic logic [31:0] sat32(input logic big, input logic [HQ_W-1:0] q,
			input logic neg);
		logic over;
		over = big || q[HQ_W-1];
		if (neg) begin
			return over ? NEG_MAX : 32'(-q);
		end
		return over ? POS_MAX : 32'(q);
	endfunction

	assign en         = !res.valid || res.ready;
	assign pair.ready = en;

	// s1: differences and magnitudes
	logic signed [DIFF_W-1:0] dx, dy;
	logic                     v_s1, sx_s1, sy_s1;
	logic [DIFF_W-1:0]        ax_s1, ay_s1;

	assign dx = coord_of(pair.data.first_x) - coord_of(pair.data.second_x);
	assign dy = coord_of(pair.data.first_y) - coord_of(pair.data.second_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= pair.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s1 <= dx[DIFF_W-1];
			sy_s1 <= dy[DIFF_W-1];
			ax_s1 <= dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
			ay_s1 <= dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
		end
	end

	// s2: squares
	logic              v_s2, sx_s2, sy_s2;
	logic [DIFF_W-1:0] ax_s2, ay_s2;
	logic [SQ_W-1:0]   sqx_s2, sqy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s2  <= sx_s1;
			sy_s2  <= sy_s1;
			ax_s2  <= ax_s1;
			ay_s2  <= ay_s1;
			sqx_s2 <= SQ_W'(ax_s1) * SQ_W'(ax_s1);
			sqy_s2 <= SQ_W'(ay_s1) * SQ_W'(ay_s1);
		end
	end

	// s3: squared length and coincidence check
	logic            v_s3;
	logic [SQ_W-1:0] sum, sum_s3;
	sq_side_t        sqs_s3;

	assign sum = sqx_s2 + sqy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s3     <= sum;
			sqs_s3.sx  <= sx_s2;
			sqs_s3.sy  <= sy_s2;
			sqs_s3.ax  <= ax_s2;
			sqs_s3.ay  <= ay_s2;
			sqs_s3.deg <= sum == '0;
		end
	end

	// square root pipe
	logic                 sq_ov;
	logic [ROOT_W-1:0]    sq_root;
	logic [SREM_W-1:0]    sq_rem;
	logic [$bits(sq_side_t)-1:0] sq_side_o;
	sq_side_t             sqo;

	elgh_sqrt #(
		.SW($bits(sq_side_t))
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s3),
		.sq       (sum_s3),
		.side     (sqs_s3),
		.out_valid(sq_ov),
		.root     (sq_root),
		.rem      (sq_rem),
		.side_out (sq_side_o)
	);

	assign sqo = sq_side_o;

	// s4: round the root to nearest
	logic       v_s4;
	logic [LEN_W-1:0] len_s4;
	sq_side_t   sqs_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= sq_ov;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			len_s4 <= LEN_W'(sq_root) + LEN_W'(SREM_W'(sq_rem) > SREM_W'(sq_root));
			sqs_s4 <= sqo;
		end
	end

	// s5: unit vector dividends with rounding offset
	logic                    v_s5;
	logic [1:0][NUM_W-1:0]   unum_s5;
	logic [LEN_W-1:0]        len_s5;
	ud_side_t                uds_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			unum_s5[0] <= (NUM_W'(sqs_s4.ax) << UNIT_SHIFT) + NUM_W'(len_s4 >> 1);
			unum_s5[1] <= (NUM_W'(sqs_s4.ay) << UNIT_SHIFT) + NUM_W'(len_s4 >> 1);
			len_s5     <= len_s4;
			uds_s5.len <= len_s4;
			uds_s5.sx  <= sqs_s4.sx;
			uds_s5.sy  <= sqs_s4.sy;
			uds_s5.deg <= sqs_s4.deg;
		end
	end

	// unit vector divider, both lanes share the length
	logic                       ud_ov;
	logic [1:0][UX_W-1:0]       ud_q;
	logic [$bits(ud_side_t)-1:0] ud_side_o;
	ud_side_t                   udo;

	elgh_div #(
		.LANES(2),
		.NW   (NUM_W),
		.DW   (LEN_W),
		.QB   (UX_W),
		.SW   ($bits(ud_side_t))
	) u_udiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s5),
		.num      (unum_s5),
		.den      (len_s5),
		.side     (uds_s5),
		.out_valid(ud_ov),
		.quo      (ud_q),
		.side_out (ud_side_o)
	);

	assign udo = ud_side_o;

	// s6: products of the unit vector, Hessian divisor
	logic              v_s6, hz_s6;
	logic [PROD_W-1:0] pxx_s6, pyy_s6, pxy_s6;
	logic [NUM_W-1:0]  dh_s6;
	logic [UX_W-1:0]   ux_s6, uy_s6;
	ud_side_t          uds_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= ud_ov;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pxx_s6 <= PROD_W'(ud_q[0]) * PROD_W'(ud_q[0]);
			pyy_s6 <= PROD_W'(ud_q[1]) * PROD_W'(ud_q[1]);
			pxy_s6 <= PROD_W'(ud_q[0]) * PROD_W'(ud_q[1]);
			dh_s6  <= NUM_W'(udo.len) << HSH;
			hz_s6  <= (NUM_W'(udo.len) >> (63 - HSH)) != '0;
			ux_s6  <= ud_q[0];
			uy_s6  <= ud_q[1];
			uds_s6 <= udo;
		end
	end

	// s7: Hessian dividends with rounding offset
	logic                  v_s7, hz_s7;
	logic [2:0][NUM_W-1:0] hn_s7;
	logic [NUM_W-1:0]      dh_s7;
	logic [UX_W-1:0]       ux_s7, uy_s7;
	ud_side_t              uds_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hn_s7[0] <= ONE_SQ - NUM_W'(pxx_s6) + (dh_s6 >> 1);
			hn_s7[1] <= NUM_W'(pxy_s6) + (dh_s6 >> 1);
			hn_s7[2] <= ONE_SQ - NUM_W'(pyy_s6) + (dh_s6 >> 1);
			dh_s7    <= dh_s6;
			hz_s7    <= hz_s6;
			ux_s7    <= ux_s6;
			uy_s7    <= uy_s6;
			uds_s7   <= uds_s6;
		end
	end

	// s8: quotient overflow check, quotient at least 2^32
	logic                  v_s8;
	logic [2:0][NUM_W-1:0] hn_s8;
	logic [NUM_W-1:0]      dh_s8;
	hd_side_t              hds_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				hds_s8.ovf[l] <= (hn_s7[l] >> HQ_W) >= dh_s7;
			end
			hn_s8      <= hn_s7;
			dh_s8      <= dh_s7;
			hds_s8.hz  <= hz_s7;
			hds_s8.len <= uds_s7.len;
			hds_s8.ux  <= ux_s7;
			hds_s8.uy  <= uy_s7;
			hds_s8.sx  <= uds_s7.sx;
			hds_s8.sy  <= uds_s7.sy;
			hds_s8.deg <= uds_s7.deg;
		end
	end

	// Hessian divider, three lanes share the scaled length
	logic                        hd_ov;
	logic [2:0][HQ_W-1:0]        hd_q;
	logic [$bits(hd_side_t)-1:0] hd_side_o;
	hd_side_t                    hdo;

	elgh_div #(
		.LANES(3),
		.NW   (NUM_W),
		.DW   (NUM_W),
		.QB   (HQ_W),
		.SW   ($bits(hd_side_t))
	) u_hdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s8),
		.num      (hn_s8),
		.den      (dh_s8),
		.side     (hds_s8),
		.out_valid(hd_ov),
		.quo      (hd_q),
		.side_out (hd_side_o)
	);

	assign hdo = hd_side_o;

	// s9: signs, saturation, coincident case; output register
	logic      v_s9;
	result_t   res_s9;
	result_t   res_n;
	logic      nxy;
	logic [2:0][HQ_W-1:0] hq;
	logic [2:0]           hbig;

	always_comb begin
		nxy = (hdo.ux != '0) && (hdo.uy != '0) && (hdo.sx == hdo.sy);
		for (int l = 0; l < 3; l++) begin
			hq[l]   = hdo.hz ? '0 : hd_q[l];
			hbig[l] = !hdo.hz && hdo.ovf[l];
		end
		res_n.edge_length = hdo.len[LEN_W-1] ? '1 : hdo.len[32:0];
		res_n.unit_x      = hdo.sx ? -$signed(32'(hdo.ux)) : $signed(32'(hdo.ux));
		res_n.unit_y      = hdo.sy ? -$signed(32'(hdo.uy)) : $signed(32'(hdo.uy));
		res_n.hess_xx     = sat32(hbig[0], hq[0], 1'b0);
		res_n.hess_xy     = sat32(hbig[1], hq[1], nxy);
		res_n.hess_yy     = sat32(hbig[2], hq[2], 1'b0);
		res_n.degenerate  = 1'b0;
		if (hdo.deg) begin
			res_n            = '0;
			res_n.degenerate = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s9 <= hd_ov;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s9 <= res_n;
		end
	end

	assign res.valid = v_s9;
	assign res.data  = res_s9;

	// a coincident pair gives zero fields with only the degenerate flag set
	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.data.degenerate |-> res.data.edge_length == '0 &&
		res.data.unit_x == '0 && res.data.unit_y == '0 && res.data.hess_xx == '0 &&
		res.data.hess_xy == '0 && res.data.hess_yy == '0)
		else $error("degenerate result with nonzero fields");

	// distinct points never round to zero length
	a_len_nz: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.data.degenerate |-> res.data.edge_length != '0)
		else $error("zero length on a distinct pair");

	// unit vector stays within one
	a_unit_rng: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> res.data.unit_x <= 32'sh4000_0000 &&
		res.data.unit_x >= -32'sh4000_0000 && res.data.unit_y <= 32'sh4000_0000 &&
		res.data.unit_y >= -32'sh4000_0000)
		else $error("unit vector out of range");

	// root is nonzero whenever the squared length is nonzero
	a_root_nz: assert property (@(posedge clk) disable iff (!arst_n)
		sq_ov && !sqo.deg |-> sq_root != '0)
		else $error("square root pipe lost the root");

endmodule

/* hw/rtl/elgh_sqrt.sv */
module elgh_sqrt #(
	parameter int SW = 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [elgh_pkg::SQ_W-1:0]     sq,
	input  logic [SW-1:0]                 side,
	output logic                          out_valid,
	output logic [elgh_pkg::ROOT_W-1:0]   root,
	output logic [elgh_pkg::SREM_W-1:0]   rem,
	output logic [SW-1:0]                 side_out
);
	import elgh_pkg::*;

	localparam int RW = SQ_W + 2;

	logic              v_s    [0:ROOT_W];
	logic [RW-1:0]     rem_s  [0:ROOT_W];
	logic [ROOT_W-1:0] root_s [0:ROOT_W];
	logic [SW-1:0]     side_s [0:ROOT_W];

	assign v_s[0]    = in_valid;
	assign rem_s[0]  = RW'(sq);
	assign root_s[0] = '0;
	assign side_s[0] = side;

	// one root bit per stage, most significant first
	for (genvar k = 0; k < ROOT_W; k++) begin : g_bit
		localparam int B = ROOT_W - 1 - k;
		logic [RW-1:0] trial;
		logic          take;

		assign trial = (RW'(root_s[k]) << (B + 1)) + (RW'(1) << (2 * B));
		assign take  = rem_s[k] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= take ? rem_s[k] - trial : rem_s[k];
				root_s[k+1] <= take ? root_s[k] | (ROOT_W'(1) << B) : root_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = v_s[ROOT_W];
	assign root      = root_s[ROOT_W];
	assign rem       = rem_s[ROOT_W][SREM_W-1:0];
	assign side_out  = side_s[ROOT_W];

endmodule

/* hw/rtl/elgh_div.sv */
module elgh_div #(
	parameter int LANES = 2,
	parameter int NW    = 64,
	parameter int DW    = 34,
	parameter int QB    = 31,
	parameter int SW    = 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [LANES-1:0][NW-1:0]      num,
	input  logic [DW-1:0]                 den,
	input  logic [SW-1:0]                 side,
	output logic                          out_valid,
	output logic [LANES-1:0][QB-1:0]      quo,
	output logic [SW-1:0]                 side_out
);

	logic                     v_s    [0:QB];
	logic [LANES-1:0][NW-1:0] rem_s  [0:QB];
	logic [LANES-1:0][QB-1:0] q_s    [0:QB];
	logic [DW-1:0]            den_s  [0:QB];
	logic [SW-1:0]            side_s [0:QB];

	assign v_s[0]    = in_valid;
	assign rem_s[0]  = num;
	assign q_s[0]    = '0;
	assign den_s[0]  = den;
	assign side_s[0] = side;

	// restoring division, one quotient bit per stage, shared divisor
	for (genvar k = 0; k < QB; k++) begin : g_bit
		localparam int B = QB - 1 - k;
		logic [LANES-1:0][NW-1:0] rem_n;
		logic [LANES-1:0][QB-1:0] q_n;

		always_comb begin
			for (int l = 0; l < LANES; l++) begin
				if ((rem_s[k][l] >> B) >= NW'(den_s[k])) begin
					rem_n[l] = rem_s[k][l] - (NW'(den_s[k]) << B);
					q_n[l]   = q_s[k][l] | (QB'(1) << B);
				end else begin
					rem_n[l] = rem_s[k][l];
					q_n[l]   = q_s[k][l];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= rem_n;
				q_s[k+1]    <= q_n;
				den_s[k+1]  <= den_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = v_s[QB];
	assign quo       = q_s[QB];
	assign side_out  = side_s[QB];

endmodule

/* tb/sv/edge_length_grad_hessian_unit_tb.sv */
module edge_length_grad_hessian_unit_tb;
	import elgh_pkg::*;

	localparam int IDLE_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 130;
	localparam int RANDOM_PAIRS = 1430;

	logic clk;
	logic arst_n;

	elgh_pair_if pair_ch ();
	elgh_res_if  res_ch ();

	edge_length_grad_hessian_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pair   (pair_ch),
		.res    (res_ch)
	);

	pair_t   pending_pairs[$];
	result_t expected_results[$];
	logic    pair_taken;
	int      burst_left;
	int      gap_left;
	int      stall_mode;
	int      mode_left;
	int      idle_cycles;
	bit      failed;

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// signed magnitude to saturated 32-bit two's complement
	function automatic logic [31:0] clamp_signed(input logic [63:0] mag, input bit neg);
		if (neg) begin
			if (mag >= 64'h8000_0000)
				return 32'h8000_0000;
			return 32'(64'd0 - mag);
		end
		return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
	endfunction

	// Hessian magnitude: num / (len * 2^28), rounded half up; zero when len >= 2^35
	function automatic logic [63:0] hess_div(input logic [63:0] num, input logic [63:0] len);
		logic [127:0] den;
		den = {64'd0, len} << 28;
		if ((len >> 35) != 0)
			return 64'd0;
		return 64'(({64'd0, num} + den / 2) / den);
	endfunction

	// length, unit vector and Hessian block of one point pair
	function automatic result_t edge_terms(input pair_t p);
		result_t r;
		logic signed [33:0] dx, dy;
		logic [127:0] ax, ay, sq, root, trial, ux, uy;
		logic [63:0] num_xx, num_yy, num_xy;
		r = '0;
		dx = 34'(signed'(p.first_x)) - 34'(signed'(p.second_x));
		dy = 34'(signed'(p.first_y)) - 34'(signed'(p.second_y));
		ax = (dx < 0) ? 128'(-dx) : 128'(dx);
		ay = (dy < 0) ? 128'(-dy) : 128'(dy);
		sq = ax * ax + ay * ay;
		if (sq == 0) begin
			r.degenerate = 1'b1;
			return r;
		end
		root = 0;
		for (int b = 33; b >= 0; b--) begin
			trial = root | (128'd1 << b);
			if (trial * trial <= sq)
				root = trial;
		end
		if (sq - root * root > root)
			root = root + 1;
		ux = ((ax << 30) + root / 2) / root;
		uy = ((ay << 30) + root / 2) / root;
		r.edge_length = (root > 128'h1_FFFF_FFFF) ? 33'h1_FFFF_FFFF : root[32:0];
		r.unit_x = clamp_signed(ux[63:0], dx < 0);
		r.unit_y = clamp_signed(uy[63:0], dy < 0);
		num_xx = (64'd1 << 60) - 64'(ux * ux);
		num_yy = (64'd1 << 60) - 64'(uy * uy);
		num_xy = 64'(ux * uy);
		r.hess_xx = clamp_signed(hess_div(num_xx, root[63:0]), 1'b0);
		r.hess_xy = clamp_signed(hess_div(num_xy, root[63:0]),
			ux != 0 && uy != 0 && ((dx < 0) == (dy < 0)));
		r.hess_yy = clamp_signed(hess_div(num_yy, root[63:0]), 1'b0);
		return r;
	endfunction

	task automatic add_pair(input logic [31:0] x0, input logic [31:0] y0,
		input logic [31:0] x1, input logic [31:0] y1);
		pair_t p;
		p.first_x = x0;
		p.first_y = y0;
		p.second_x = x1;
		p.second_y = y1;
		pending_pairs.push_back(p);
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
		input logic [63:0] got);
		if (want !== got) begin
			$display("%0t %s: expected %h, actual %h", $time, name, want, got);
			failed = 1'b1;
		end
	endtask

	// small delta around a random base, for short edges
	function automatic logic [31:0] near(input logic [31:0] base);
		return base + 32'($signed($urandom_range(0, 8)) - 4);
	endfunction

	// stimulus
	initial begin
		logic [31:0] bx, by;
		int kind;
		failed = 1'b0;
		add_pair(0, 0, 0, 0);                                   // coincident at origin
		add_pair(32'h1234_5678, 32'h8765_4321, 32'h1234_5678, 32'h8765_4321);
		add_pair(1, 0, 0, 0);                                   // one raw unit
		add_pair(0, 0, 0, 1);
		add_pair(1, 1, 0, 0);
		add_pair(0, 0, 1, 32'hFFFF_FFFF);
		add_pair(32'h0001_0000, 0, 0, 0);                       // unit length
		add_pair(0, 32'h0003_0000, 32'h0004_0000, 0);           // 3-4-5
		add_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
		add_pair(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		add_pair(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
		add_pair(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
		add_pair(32'h7FFF_FFFF, 0, 32'h8000_0000, 0);           // long axis edge
		add_pair(0, 32'h8000_0000, 0, 32'h7FFF_FFFF);
		add_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0);
		add_pair(2, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 1);
		add_pair(32'h4000_0000, 32'hC000_0000, 32'hC000_0000, 32'h4000_0000);
		add_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		add_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFE);
		add_pair(5, 7, 3, 2);

		for (int i = 0; i < RANDOM_PAIRS; i++) begin
			kind = $urandom_range(0, 9);
			bx = $urandom;
			by = $urandom;
			case (kind)
				0, 1, 2: begin
					add_pair($urandom, $urandom, $urandom, $urandom);
				end
				3, 4: begin
					add_pair(bx, by, near(bx), near(by));
				end
				5, 6: begin
					add_pair(bx, by, bx + ($urandom >> $urandom_range(8, 31)),
						by - ($urandom >> $urandom_range(8, 31)));
				end
				7: begin
					add_pair(bx, by, bx, by + ($urandom >> $urandom_range(0, 31)));
				end
				8: begin
					add_pair(bx, by, bx, by);
				end
				default: begin
					add_pair(bx, by, bx - ($urandom >> $urandom_range(14, 20)),
						by + ($urandom >> $urandom_range(14, 20)));
				end
			endcase
		end

		while (pending_pairs.size() != 0 || pair_ch.valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (!failed && expected_results.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// reset and initial drive
	initial begin
		arst_n = 1'b0;
		pair_ch.valid = 1'b0;
		pair_ch.data = '0;
		res_ch.ready = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// sender: bursts with random gaps
	initial begin
		burst_left = 0;
		gap_left = 0;
	end
	always @(negedge clk) begin
		if (arst_n && !(pair_ch.valid && !pair_taken)) begin
			if (gap_left > 0) begin
				pair_ch.valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_pairs.size() != 0) begin
				pair_ch.valid <= 1'b1;
				pair_ch.data <= pending_pairs.pop_front();
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				pair_ch.valid <= 1'b0;
			end
		end
	end

	// receiver: random stall pattern, redrawn whenever its mode counter runs out
	initial begin
		stall_mode = 0;
		mode_left = 0;
	end
	always @(negedge clk) begin
		if (arst_n) begin
			if (mode_left == 0) begin
				stall_mode <= $urandom_range(0, 3);
				mode_left <= $urandom_range(16, 96);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (stall_mode)
				0: res_ch.ready <= 1'b1;
				1: res_ch.ready <= 1'($urandom_range(0, 1));
				2: res_ch.ready <= ($urandom_range(0, 3) == 0);
				default: res_ch.ready <= ((mode_left % 8) < 5);
			endcase
		end
	end

	// monitor: predict on accepted pairs, check accepted results
	always @(posedge clk) begin
		result_t want, got;
		pair_taken <= pair_ch.valid && pair_ch.ready;
		if (pair_ch.valid && pair_ch.ready)
			expected_results.push_back(edge_terms(pair_ch.data));
		if (res_ch.valid && res_ch.ready) begin
			got = res_ch.data;
			if (expected_results.size() == 0) begin
				$display("%0t unexpected result beat: expected none, actual %h", $time, got);
				failed = 1'b1;
			end else begin
				want = expected_results.pop_front();
				check_field("edge_length", want.edge_length, got.edge_length);
				check_field("unit_x", want.unit_x, got.unit_x);
				check_field("unit_y", want.unit_y, got.unit_y);
				check_field("hess_xx", want.hess_xx, got.hess_xx);
				check_field("hess_xy", want.hess_xy, got.hess_xy);
				check_field("hess_yy", want.hess_yy, got.hess_yy);
				check_field("degenerate", want.degenerate, got.degenerate);
			end
		end
	end

	// watchdog on cycles without any beat
	initial idle_cycles = 0;
	always @(posedge clk) begin
		if ((pair_ch.valid && pair_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

endmodule

/* sim.f */
hw/rtl/elgh_pkg.sv
hw/rtl/elgh_if.sv
hw/rtl/elgh_sqrt.sv
hw/rtl/elgh_div.sv
hw/rtl/edge_length_grad_hessian_unit.sv
tb/sv/edge_length_grad_hessian_unit_tb.sv
